### src/barometric_sensor_compensation_assert.svh
// assertion helpers for the compensation pipeline
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BSC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### src/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

   localparam int ADC_WIDTH   = 20;
   localparam int CAL_WIDTH   = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int OUT_WIDTH   = 32;
   localparam int DIV_BITS    = 64;
   localparam int DIV_REM_W   = 31;
   localparam int PRE_STAGES  = 12;
   localparam int POST_STAGES = 7;

   localparam logic [24:0] TEMP_OFFSET = 25'd128000;
   localparam logic [20:0] PRESS_BASE  = 21'd1048576;
   localparam logic [11:0] PRESS_SCALE = 12'd3125;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_CALIB    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CALIB_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CALIB_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_CALIB_C = 2'd3;

   typedef struct packed {
      logic [31:0]          temp;
      logic [DIV_REM_W-1:0] ad;
      logic                 qneg;
      logic                 nz;
   } div_side_type;

endpackage
`default_nettype wire

### src/barometric_sensor_compensation.sv
// channel  | ports                                  | handshake
// ---------+----------------------------------------+-------------------------------
// request  | req_adc_temperature, req_adc_pressure   | beat when start && !busy
// response | rsp_temperature_centi, rsp_pressure_*  | one-cycle beat on rsp_valid
// csr      | csr_index, csr_write_data               | write when csr_write_enable
//
// a beat is taken every cycle; busy stays low
// each result passes through 12 front stages of multiply
// and add, 64 one-bit stages of the restoring divider, 7 back stages
// reset clears the stage valid bits and the calibration registers
// the response side cannot stall, so the pipeline never holds
`default_nettype none
`include "barometric_sensor_compensation_assert.svh"
module barometric_sensor_compensation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [bsc_pkg::ADC_WIDTH-1:0]     req_adc_temperature,
   input  wire logic [bsc_pkg::ADC_WIDTH-1:0]     req_adc_pressure,
   output logic                                   rsp_valid,
   output logic signed [bsc_pkg::OUT_WIDTH-1:0]   rsp_temperature_centi,
   output logic [bsc_pkg::OUT_WIDTH-1:0]          rsp_pressure_q24_8,
   output logic                                   rsp_pressure_valid,
   input  wire logic                              csr_write_enable,
   input  wire logic [bsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bsc_pkg::CAL_WIDTH-1:0]     csr_write_data
);
   import bsc_pkg::*;

   // calibration registers
   logic [CAL_WIDTH-1:0] temp_calib_ff, press_a_ff, press_b_ff, press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff    <= '0;
         press_b_ff    <= '0;
         press_c_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TEMP_CALIB:    temp_calib_ff <= csr_write_data;
            CSR_PRESS_CALIB_A: press_a_ff    <= csr_write_data;
            CSR_PRESS_CALIB_B: press_b_ff    <= csr_write_data;
            CSR_PRESS_CALIB_C: press_c_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = temp_calib_ff[15:0];
   assign t2 = $signed(temp_calib_ff[31:16]);
   assign t3 = $signed(temp_calib_ff[47:32]);
   assign p1 = press_a_ff[15:0];
   assign p2 = $signed(press_a_ff[31:16]);
   assign p3 = $signed(press_a_ff[47:32]);
   assign p4 = $signed(press_b_ff[15:0]);
   assign p5 = $signed(press_b_ff[31:16]);
   assign p6 = $signed(press_b_ff[47:32]);
   assign p7 = $signed(press_c_ff[15:0]);
   assign p8 = $signed(press_c_ff[31:16]);
   assign p9 = $signed(press_c_ff[47:32]);

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // front stages
   logic [PRE_STAGES:1] pre_v_ff;
   always_ff @(posedge clock) begin
      if (reset) pre_v_ff <= '0;
      else       pre_v_ff <= {pre_v_ff[PRE_STAGES-1:1], accept};
   end

   logic signed [17:0] a_ff, a_in;
   logic signed [16:0] b_ff, b_in;
   logic [ADC_WIDTH-1:0] ap_ff [1:8];
   assign a_in = $signed({1'b0, req_adc_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
   assign b_in = $signed({1'b0, req_adc_temperature[19:4]}) - $signed({1'b0, t1});

   logic signed [33:0] m1_ff, bsq_in;
   logic [31:0]        bb_ff;
   logic signed [22:0] v1_ff;
   logic signed [36:0] m2_ff;
   logic signed [23:0] t_fine_ff;
   logic signed [27:0] tm_in;
   logic signed [31:0] temp_ff;
   logic signed [24:0] x_ff;
   logic signed [49:0] xsq_in;
   logic [48:0]        xx_ff;
   logic signed [40:0] xp5_ff, xp2_ff, xp5b_ff, xp2b_ff;
   logic signed [65:0] y6w_in, x3w_in;
   logic signed [63:0] y6_ff, x3_ff, y_ff, xs_ff, xa_ff, nm_ff;
   logic [47:0]        xlo_ff;
   logic [31:0]        xhi_ff, nhi_ff;
   logic [43:0]        nlo_ff;
   logic [63:0]        prodx_in, num_ff, num_in;
   logic [30:0]        xd_ff;
   logic [20:0]        pn_in;
   logic signed [31:0] tpipe_ff [6:11];
   logic [63:0]        an_ff;
   div_side_type       s12_sb_ff;

   assign bsq_in   = b_ff * b_ff;
   assign tm_in    = 28'(t_fine_ff) * 28'sd5 + 28'sd128;
   assign xsq_in   = x_ff * x_ff;
   assign y6w_in   = $signed({1'b0, xx_ff}) * p6;
   assign x3w_in   = $signed({1'b0, xx_ff}) * p3;
   assign pn_in    = PRESS_BASE - {1'b0, ap_ff[8]};
   assign prodx_in = {16'b0, xlo_ff} + {xhi_ff, 32'b0};
   assign num_in   = {20'b0, nlo_ff} + {nhi_ff, 32'b0};

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      ap_ff[1] <= req_adc_pressure;
      for (int i = 2; i <= 8; i++) ap_ff[i] <= ap_ff[i-1];
      m1_ff <= a_ff * t2;
      bb_ff <= bsq_in[31:0];
      v1_ff <= 23'(m1_ff >>> 11);
      m2_ff <= $signed({1'b0, bb_ff[31:12]}) * t3;
      t_fine_ff <= 24'(v1_ff) + 24'(m2_ff >>> 14);
      temp_ff <= 32'(tm_in >>> 8);
      x_ff    <= 25'(t_fine_ff) - $signed(TEMP_OFFSET);
      tpipe_ff[6] <= temp_ff;
      for (int i = 7; i <= 11; i++) tpipe_ff[i] <= tpipe_ff[i-1];
      xx_ff  <= xsq_in[48:0];
      xp5_ff <= x_ff * p5;
      xp2_ff <= x_ff * p2;
      y6_ff  <= y6w_in[63:0];
      x3_ff  <= x3w_in[63:0];
      xp5b_ff <= xp5_ff;
      xp2b_ff <= xp2_ff;
      y_ff  <= y6_ff + $signed({{6{xp5b_ff[40]}}, xp5b_ff, 17'b0})
                     + $signed({{13{p4[15]}}, p4, 35'b0});
      xs_ff <= (x3_ff >>> 8) + $signed({{11{xp2b_ff[40]}}, xp2b_ff, 12'b0});
      xa_ff <= xs_ff + 64'sh0000_8000_0000_0000;
      nm_ff <= $signed({12'b0, pn_in, 31'b0}) - y_ff;
      xlo_ff <= {16'b0, xa_ff[31:0]} * {32'b0, p1};
      xhi_ff <= xa_ff[63:32] * {16'b0, p1};
      nlo_ff <= {12'b0, nm_ff[31:0]} * {32'b0, PRESS_SCALE};
      nhi_ff <= nm_ff[63:32] * {20'b0, PRESS_SCALE};
      xd_ff  <= prodx_in[63:33];
      num_ff <= num_in;
      // magnitudes and signs for the divider
      an_ff          <= num_ff[63] ? (64'd0 - num_ff) : num_ff;
      s12_sb_ff.ad   <= xd_ff[30] ? (31'd0 - xd_ff) : xd_ff;
      s12_sb_ff.qneg <= num_ff[63] ^ xd_ff[30];
      s12_sb_ff.nz   <= |xd_ff;
      s12_sb_ff.temp <= tpipe_ff[11];
   end

   // restoring divider, one quotient bit per stage
   logic                 dv_ff   [DIV_BITS];
   logic [63:0]          dnq_ff  [DIV_BITS];
   logic [DIV_REM_W-1:0] drem_ff [DIV_BITS];
   div_side_type         dsb_ff  [DIV_BITS];

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      logic                 v_src;
      logic [63:0]          nq_src;
      logic [DIV_REM_W-1:0] rem_src;
      div_side_type         sb_src;
      logic [DIV_REM_W:0]   trial;
      logic                 ge;
      if (k == 0) begin : g_first
         assign v_src   = pre_v_ff[PRE_STAGES];
         assign nq_src  = an_ff;
         assign rem_src = '0;
         assign sb_src  = s12_sb_ff;
      end else begin : g_next
         assign v_src   = dv_ff[k-1];
         assign nq_src  = dnq_ff[k-1];
         assign rem_src = drem_ff[k-1];
         assign sb_src  = dsb_ff[k-1];
      end
      assign trial = {rem_src, nq_src[63]};
      assign ge    = trial >= {1'b0, sb_src.ad};
      always_ff @(posedge clock) begin
         if (reset) dv_ff[k] <= 1'b0;
         else       dv_ff[k] <= v_src;
         dnq_ff[k]  <= {nq_src[62:0], ge};
         drem_ff[k] <= ge ? DIV_REM_W'(trial - {1'b0, sb_src.ad}) : trial[DIV_REM_W-1:0];
         dsb_ff[k]  <= sb_src;
      end
   end

   // back stages
   logic [POST_STAGES-1:0] post_v_ff;
   always_ff @(posedge clock) begin
      if (reset) post_v_ff <= '0;
      else       post_v_ff <= {post_v_ff[POST_STAGES-2:0], dv_ff[DIV_BITS-1]};
   end

   logic signed [31:0] ptemp_ff [0:5];
   logic               pnz_ff   [0:5];
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, h_in;
   logic signed [63:0] hsq_ff, c2_ff, c2b_ff, c2c_ff, prod9_ff, sum_ff, pp8_in;
   logic [63:0]        hsql_ff;
   logic [31:0]        hsqc_ff, p8h_ff, q9h_ff;
   logic signed [48:0] p8l_ff, q9l_ff;
   logic [31:0]        res_in;

   assign h_in   = p0_ff >>> 13;
   assign pp8_in = $signed({{15{p8l_ff[48]}}, p8l_ff}) + $signed({p8h_ff, 32'b0});
   assign res_in = sum_ff[39:8] + {{12{p7[15]}}, p7, 4'b0};

   always_ff @(posedge clock) begin
      p0_ff       <= dsb_ff[DIV_BITS-1].qneg ? $signed(64'd0 - dnq_ff[DIV_BITS-1])
                                             : $signed(dnq_ff[DIV_BITS-1]);
      ptemp_ff[0] <= dsb_ff[DIV_BITS-1].temp;
      pnz_ff[0]   <= dsb_ff[DIV_BITS-1].nz;
      for (int i = 1; i <= 5; i++) begin
         ptemp_ff[i] <= ptemp_ff[i-1];
         pnz_ff[i]   <= pnz_ff[i-1];
      end
      // h squared and p times p8, both modulo 2^64
      hsql_ff <= {32'b0, h_in[31:0]} * {32'b0, h_in[31:0]};
      hsqc_ff <= h_in[31:0] * h_in[63:32];
      p8l_ff  <= $signed({1'b0, p0_ff[31:0]}) * p8;
      p8h_ff  <= p0_ff[63:32] * {{16{p8[15]}}, p8};
      p1_ff   <= p0_ff;
      hsq_ff  <= $signed(hsql_ff + {hsqc_ff[30:0], 1'b0, 32'b0});
      c2_ff   <= pp8_in >>> 19;
      p2_ff   <= p1_ff;
      q9l_ff  <= $signed({1'b0, hsq_ff[31:0]}) * p9;
      q9h_ff  <= hsq_ff[63:32] * {{16{p9[15]}}, p9};
      c2b_ff  <= c2_ff;
      p3_ff   <= p2_ff;
      prod9_ff <= $signed({{15{q9l_ff[48]}}, q9l_ff}) + $signed({q9h_ff, 32'b0});
      c2c_ff  <= c2b_ff;
      p4_ff   <= p3_ff;
      sum_ff  <= p4_ff + (prod9_ff >>> 25) + c2c_ff;
      rsp_temperature_centi <= ptemp_ff[5];
      rsp_pressure_valid    <= pnz_ff[5];
      rsp_pressure_q24_8    <= pnz_ff[5] ? res_in : '0;
   end

   assign rsp_valid = post_v_ff[POST_STAGES-1];

   `BSC_ASSERT_NOW(a_zero_div_press, rsp_valid && !rsp_pressure_valid, rsp_pressure_q24_8 == '0, "pressure not forced to zero")
   `BSC_ASSERT_NOW(a_nz_flag, dv_ff[DIV_BITS-1], dsb_ff[DIV_BITS-1].nz == (dsb_ff[DIV_BITS-1].ad != '0), "divisor flag lost")
   `BSC_ASSERT_NOW(a_rem_bound, dv_ff[DIV_BITS-1] && dsb_ff[DIV_BITS-1].nz, drem_ff[DIV_BITS-1] < dsb_ff[DIV_BITS-1].ad, "remainder not below divisor")
   `BSC_ASSERT_NEXT(a_div_enter, pre_v_ff[PRE_STAGES], dv_ff[0], "beat dropped at divider entry")

endmodule
`default_nettype wire
